// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL that checks its own behavior (the parser top level).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Same-cycle assertion failed.");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Next-cycle assertion failed.");

`endif

// File: hw/rtl/phvp_pkg.sv
// Package with types, codes and keyword tables of the privacy header value parser.
`timescale 1ns / 1ps
`default_nettype none
package phvp_pkg;

  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_EMPTY         = 3'd1;
  localparam logic [2:0] ERR_BAD_VALUE     = 3'd2;
  localparam logic [2:0] ERR_NO_VALUE      = 3'd3;
  localparam logic [2:0] ERR_SEMI_EXPECTED = 3'd4;
  localparam logic [2:0] ERR_NONE_COMBINED = 3'd5;

  localparam logic [2:0] KW_CRITICAL = 3'd0;
  localparam logic [2:0] KW_HEADER   = 3'd1;
  localparam logic [2:0] KW_HISTORY  = 3'd2;
  localparam logic [2:0] KW_ID       = 3'd3;
  localparam logic [2:0] KW_NONE     = 3'd4;
  localparam logic [2:0] KW_SESSION  = 3'd5;
  localparam logic [2:0] KW_USER     = 3'd6;

  localparam logic [6:0] BIT_NONE = 7'h08;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Keyword text padded with spaces to eight characters, first character in the top byte.
  localparam logic [63:0] KW_TEXT [8] = '{
    "critical", "header  ", "history ", "id      ",
    "none    ", "session ", "user    ", "        "
  };
  localparam logic [3:0] KW_LEN [8] = '{4'd8, 4'd6, 4'd7, 4'd2, 4'd4, 4'd7, 4'd4, 4'd0};
  localparam logic [6:0] KW_BIT [8] = '{
    7'h10, 7'h02, 7'h40, 7'h20, 7'h08, 7'h04, 7'h01, 7'h00
  };

  typedef struct packed {
    logic       has_char;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] error_code;
    logic [6:0] privacy_mask;
  } result_t;

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
    logic [63:0] txt;
    txt = KW_TEXT[k];
    return txt[6'(63 - 8 * int'(p)) -: 8];
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/phvp_in_if.sv
// Channel interface that carries one header body character item.
`timescale 1ns / 1ps
`default_nettype none
interface phvp_in_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] ch;
  logic       last;

  modport source(output valid, output has_char, output ch, output last, input ready);
  modport sink(input valid, input has_char, input ch, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/phvp_out_if.sv
// Channel interface that carries one parse result item.
`timescale 1ns / 1ps
`default_nettype none
interface phvp_out_if;
  logic       valid;
  logic       ready;
  logic       ok;
  logic [2:0] error_code;
  logic [6:0] privacy_mask;

  modport source(output valid, output ok, output error_code, output privacy_mask,
                 input ready);
  modport sink(input valid, input ok, input error_code, input privacy_mask,
               output ready);
endinterface
`default_nettype wire

// File: hw/rtl/privacy_header_value_parser_top.sv
// Top level of the privacy header value parser.
//
//   Channel  Direction  Item contents
//   in_i     sink       has_char, ch, last
//   out_o    source     ok, error_code, privacy_mask
//
// One item is accepted per cycle while no last item waits in the input register; each
// item passes through the input register and updates the parser state on leaving it,
// and a last item's result is written into the result register as it leaves. The state
// step between the input register and the result register is combinational.
// Reset clears both stage valid flags and returns the parser to the leading
// whitespace phase. A last item waits in the input register while an earlier result
// is held and not taken; other items keep flowing.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module privacy_header_value_parser_top
  import phvp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  phvp_in_if.sink     in_i,
  phvp_out_if.source  out_o
);

  item_t   in_item;
  item_t   item_q;
  logic    item_valid;
  logic    advance;
  logic    out_can_take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.has_char = in_i.has_char;
  assign in_item.ch       = in_i.ch;
  assign in_item.last     = in_i.last;

  assign advance = item_valid && (!item_q.last || out_can_take);

  phvp_in_stage u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .item_i   (in_item),
    .advance_i(advance),
    .valid_o  (item_valid),
    .item_o   (item_q)
  );

  phvp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .item_i     (item_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  phvp_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_valid),
    .res_i     (res),
    .can_take_o(out_can_take),
    .valid_o   (out_o.valid),
    .ready_i   (out_o.ready),
    .res_o     (out_res)
  );

  assign out_o.ok           = out_res.ok;
  assign out_o.error_code   = out_res.error_code;
  assign out_o.privacy_mask = out_res.privacy_mask;

  `ASSERT_SAME(a_ok_matches_code, out_o.valid, out_o.ok == (out_o.error_code == ERR_NONE))
  `ASSERT_SAME(a_err_mask_zero, out_o.valid && !out_o.ok, out_o.privacy_mask == 7'd0)
  `ASSERT_SAME(a_no_overwrite, res_valid, out_can_take)
  `ASSERT_NEXT(a_result_follows, res_valid, out_o.valid)

endmodule
`default_nettype wire

// File: hw/rtl/phvp_in_stage.sv
// Input register stage that holds one accepted character item.
`timescale 1ns / 1ps
`default_nettype none
module phvp_in_stage
  import phvp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  output logic       ready_o,
  input  wire item_t item_i,
  input  wire logic  advance_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// File: hw/rtl/phvp_core.sv
// Parser state and per-item transition logic that forms the result on the last item.
`timescale 1ns / 1ps
`default_nettype none
module phvp_core
  import phvp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_WORD,
    PH_AFTER_VALUE,
    PH_AFTER_SEMI
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] cand_q, cand_d;
  logic [3:0] pos_q, pos_d;
  logic [6:0] mask_q, mask_d;
  logic [2:0] err_q, err_d;

  logic [7:0] c;
  logic [2:0] kk;
  logic [2:0] start_k;
  logic       start_hit;
  logic [2:0] fin_err;

  always_comb begin
    phase_d   = phase_q;
    cand_d    = cand_q;
    pos_d     = pos_q;
    mask_d    = mask_q;
    err_d     = err_q;
    c         = to_lower(item_i.ch);
    kk        = (cand_q == KW_HEADER && pos_q == 4'd1 && c == "i") ? KW_HISTORY : cand_q;
    start_hit = 1'b1;
    start_k   = KW_CRITICAL;
    fin_err   = ERR_NONE;
    res_o     = '0;

    case (c)
      "c": start_k = KW_CRITICAL;
      "h": start_k = KW_HEADER;
      "i": start_k = KW_ID;
      "n": start_k = KW_NONE;
      "s": start_k = KW_SESSION;
      "u": start_k = KW_USER;
      default: start_hit = 1'b0;
    endcase

    if (step_i && item_i.has_char && err_q == ERR_NONE) begin
      unique case (phase_q)
        PH_LEAD, PH_AFTER_SEMI: begin
          if (!is_ws(c)) begin
            if (start_hit) begin
              cand_d  = start_k;
              pos_d   = 4'd1;
              phase_d = PH_WORD;
            end else begin
              err_d = ERR_BAD_VALUE;
            end
          end
        end
        PH_WORD: begin
          if (pos_q < KW_LEN[cand_q]) begin
            cand_d = kk;
            if (c != kw_char(kk, pos_q[2:0])) begin
              err_d = ERR_BAD_VALUE;
            end else begin
              pos_d = pos_q + 4'd1;
              if (pos_d == KW_LEN[kk]) begin
                mask_d = mask_q | KW_BIT[kk];
              end
            end
          end else if (is_ws(c)) begin
            phase_d = PH_AFTER_VALUE;
          end else if (c == CH_SEMI) begin
            phase_d = PH_AFTER_SEMI;
          end else if (c == CH_NUL) begin
            err_d = ERR_SEMI_EXPECTED;
          end else begin
            err_d = ERR_BAD_VALUE;
          end
        end
        PH_AFTER_VALUE: begin
          if (c == CH_SEMI) begin
            phase_d = PH_AFTER_SEMI;
          end else if (!is_ws(c)) begin
            err_d = ERR_SEMI_EXPECTED;
          end
        end
        default: phase_d = PH_LEAD;
      endcase
    end

    if (step_i && item_i.last) begin
      fin_err = err_d;
      if (err_d == ERR_NONE) begin
        if (phase_d == PH_LEAD) begin
          fin_err = ERR_EMPTY;
        end else if (phase_d == PH_WORD && pos_d != KW_LEN[cand_d]) begin
          fin_err = ERR_BAD_VALUE;
        end else if (phase_d == PH_AFTER_SEMI) begin
          fin_err = ERR_NO_VALUE;
        end else if ((mask_d & BIT_NONE) != '0 && (mask_d & ~BIT_NONE) != '0) begin
          fin_err = ERR_NONE_COMBINED;
        end
      end
      res_o.ok           = (fin_err == ERR_NONE);
      res_o.error_code   = fin_err;
      res_o.privacy_mask = (fin_err == ERR_NONE) ? mask_d : '0;
      phase_d = PH_LEAD;
      cand_d  = '0;
      pos_d   = '0;
      mask_d  = '0;
      err_d   = ERR_NONE;
    end
  end

  assign res_valid_o = step_i && item_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      cand_q  <= '0;
      pos_q   <= '0;
      mask_q  <= '0;
      err_q   <= ERR_NONE;
    end else begin
      phase_q <= phase_d;
      cand_q  <= cand_d;
      pos_q   <= pos_d;
      mask_q  <= mask_d;
      err_q   <= err_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/phvp_out_stage.sv
// Result register stage that holds one result item until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module phvp_out_stage
  import phvp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  output logic         can_take_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_take_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

// File: tb/sv/privacy_header_value_parser_top_tb.sv
`timescale 1ns / 1ps
// Testbench that streams privacy header bodies into the parser and checks every verdict.
module privacy_header_value_parser_top_tb;
  import phvp_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1400;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef enum logic [1:0] {P_LEAD, P_WORD, P_AFTER_VALUE, P_AFTER_SEMI} parse_phase_e;

  typedef struct {
    string      body;
    bit         tail_en;
    logic [7:0] tail;
    bit         bare_end;
    bit         typed;
    result_t    verdict;
  } body_case_t;

  logic clk_i;
  logic rst_ni;

  phvp_in_if  in_ch ();
  phvp_out_if out_ch ();

  privacy_header_value_parser_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  string      kw_spell [7] = '{"critical", "header", "history", "id", "none", "session", "user"};
  logic [6:0] kw_flag  [7] = '{7'h10, 7'h02, 7'h40, 7'h20, 7'h08, 7'h04, 7'h01};

  body_case_t dir_cases [22] = '{
    '{"",                  1'b0, 8'h00, 1'b1, 1'b1, '{1'b0, ERR_EMPTY, 7'h00}},
    '{" \t\r\n",           1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_EMPTY, 7'h00}},
    '{"user",              1'b0, 8'h00, 1'b0, 1'b1, '{1'b1, ERR_NONE, 7'h01}},
    '{"HEADER",            1'b0, 8'h00, 1'b0, 1'b1, '{1'b1, ERR_NONE, 7'h02}},
    '{"none",              1'b0, 8'h00, 1'b0, 1'b1, '{1'b1, ERR_NONE, 7'h08}},
    '{"critical;id;History", 1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{" session ; user\t", 1'b0, 8'h00, 1'b0, 1'b0, '0},
    '{"none;user",         1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_NONE_COMBINED, 7'h00}},
    '{"x",                 1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_BAD_VALUE, 7'h00}},
    '{"usr",               1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_BAD_VALUE, 7'h00}},
    '{"use",               1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_BAD_VALUE, 7'h00}},
    '{"userx",             1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_BAD_VALUE, 7'h00}},
    '{"user",              1'b1, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_SEMI_EXPECTED, 7'h00}},
    '{"user",              1'b1, 8'hFF, 1'b0, 1'b1, '{1'b0, ERR_BAD_VALUE, 7'h00}},
    '{"",                  1'b1, 8'hFF, 1'b0, 1'b1, '{1'b0, ERR_BAD_VALUE, 7'h00}},
    '{"user;",             1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_NO_VALUE, 7'h00}},
    '{"user x",            1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_SEMI_EXPECTED, 7'h00}},
    '{"user;user",         1'b0, 8'h00, 1'b0, 1'b1, '{1'b1, ERR_NONE, 7'h01}},
    '{"bad;user",          1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_BAD_VALUE, 7'h00}},
    '{"id;;none",          1'b0, 8'h00, 1'b0, 1'b1, '{1'b0, ERR_BAD_VALUE, 7'h00}},
    '{"id",                1'b0, 8'h00, 1'b1, 1'b1, '{1'b1, ERR_NONE, 7'h20}},
    '{"sEsSiOn;HeAdEr;hIsToRy;cRiTiCaL;iD;uSeR", 1'b0, 8'h00, 1'b0, 1'b0, '0}
  };

  parse_phase_e pm_phase;
  logic [2:0]   pm_kw;
  logic [3:0]   pm_pos;
  logic [6:0]   pm_seen;
  logic [2:0]   pm_err;

  result_t     expected_verdicts [$];
  bit          typed_pending = 1'b0;
  result_t     typed_verdict;
  int unsigned tx_idle_pct = 19;
  int unsigned rx_idle_pct = 51;
  bit          hold_req = 1'b0;
  int unsigned fail_count = 0;
  int unsigned bodies_sent = 0;
  int unsigned chars_sent = 0;
  int unsigned clean_verdicts = 0;
  int unsigned error_verdicts = 0;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0D;
      default: return 8'h0A;
    endcase
  endfunction

  task automatic clear_parser();
    pm_phase = P_LEAD;
    pm_kw    = '0;
    pm_pos   = '0;
    pm_seen  = '0;
    pm_err   = ERR_NONE;
  endtask

  task automatic parse_step(input item_t it);
    logic [7:0] c;
    logic [2:0] e;
    result_t    r;
    c = fold_lower(it.ch);
    if (it.has_char && pm_err == ERR_NONE) begin
      case (pm_phase)
        P_LEAD, P_AFTER_SEMI: if (!is_blank(c)) begin
          case (c)
            "c": pm_kw = KW_CRITICAL;
            "h": pm_kw = KW_HEADER;
            "i": pm_kw = KW_ID;
            "n": pm_kw = KW_NONE;
            "s": pm_kw = KW_SESSION;
            "u": pm_kw = KW_USER;
            default: pm_err = ERR_BAD_VALUE;
          endcase
          if (pm_err == ERR_NONE) begin
            pm_phase = P_WORD;
            pm_pos   = 4'd1;
          end
        end
        P_WORD: begin
          if (pm_pos < kw_spell[pm_kw].len()) begin
            // After an h, an i turns the header candidate into history.
            if (pm_kw == KW_HEADER && pm_pos == 4'd1 && c == "i") pm_kw = KW_HISTORY;
            if (c != kw_spell[pm_kw][pm_pos]) begin
              pm_err = ERR_BAD_VALUE;
            end else begin
              pm_pos++;
              if (pm_pos == kw_spell[pm_kw].len()) pm_seen |= kw_flag[pm_kw];
            end
          end else if (is_blank(c)) begin
            pm_phase = P_AFTER_VALUE;
          end else if (c == CH_SEMI) begin
            pm_phase = P_AFTER_SEMI;
          end else if (c == CH_NUL) begin
            pm_err = ERR_SEMI_EXPECTED;
          end else begin
            pm_err = ERR_BAD_VALUE;
          end
        end
        default: begin
          if (c == CH_SEMI) pm_phase = P_AFTER_SEMI;
          else if (!is_blank(c)) pm_err = ERR_SEMI_EXPECTED;
        end
      endcase
    end
    if (it.last) begin
      e = pm_err;
      if (e == ERR_NONE) begin
        if (pm_phase == P_LEAD) e = ERR_EMPTY;
        else if (pm_phase == P_WORD && pm_pos != kw_spell[pm_kw].len()) e = ERR_BAD_VALUE;
        else if (pm_phase == P_AFTER_SEMI) e = ERR_NO_VALUE;
        else if ((pm_seen & BIT_NONE) != '0 && (pm_seen & ~BIT_NONE) != '0)
          e = ERR_NONE_COMBINED;
      end
      r.ok           = (e == ERR_NONE);
      r.error_code   = e;
      r.privacy_mask = (e == ERR_NONE) ? pm_seen : 7'h00;
      if (typed_pending) begin
        r = typed_verdict;
        typed_pending = 1'b0;
      end
      expected_verdicts.push_back(r);
      clear_parser();
    end
  endtask

  task automatic offer(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.has_char <= it.has_char;
    in_ch.ch       <= it.ch;
    in_ch.last     <= it.last;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    parse_step(it);
    if (it.has_char) chars_sent++;
  endtask

  task automatic send_body(input logic [7:0] text [$], input bit bare_end,
                           input int unsigned noop_pct);
    item_t it;
    foreach (text[i]) begin
      if ($urandom_range(99) < noop_pct) begin
        it = '{1'b0, 8'($urandom), 1'b0};
        offer(it);
      end
      it.has_char = 1'b1;
      it.ch       = text[i];
      it.last     = (i == text.size() - 1) && !bare_end;
      offer(it);
    end
    if (bare_end || text.size() == 0) begin
      it = '{1'b0, 8'($urandom), 1'b1};
      offer(it);
    end
    bodies_sent++;
  endtask

  task automatic make_body(output logic [7:0] text [$], output bit bare_end);
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    logic [7:0]  c;
    string       alphabet;
    alphabet = "chinsuedrtoal;;  ";
    text = {};
    if ($urandom_range(99) < 75) begin
      repeat ($urandom_range(2)) text.push_back(blank_char());
      n = $urandom_range(1, 3);
      for (int w = 0; w < n; w++) begin
        if (w > 0) begin
          repeat ($urandom_range(2)) text.push_back(blank_char());
          text.push_back(CH_SEMI);
          repeat ($urandom_range(2)) text.push_back(blank_char());
        end
        k = $urandom_range(6);
        for (int j = 0; j < kw_spell[k].len(); j++) begin
          c = kw_spell[k][j];
          if ($urandom_range(1) == 1) c -= 8'd32;
          text.push_back(c);
        end
      end
      repeat ($urandom_range(1)) text.push_back(blank_char());
      if ($urandom_range(99) < 25) begin
        pick = $urandom_range(text.size() - 1);
        case ($urandom_range(3))
          0: text[pick] = 8'($urandom);
          1: text.delete(pick);
          2: text = text[0:pick];
          default: text.push_back(CH_SEMI);
        endcase
      end
    end else begin
      repeat ($urandom_range(6)) begin
        if ($urandom_range(1) == 1) text.push_back(8'($urandom));
        else text.push_back(alphabet[$urandom_range(alphabet.len() - 1)]);
      end
    end
    bare_end = ($urandom_range(99) < 10);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result ok=%0b code=%0d mask=%h", $time, out_ch.ok,
                 out_ch.error_code, out_ch.privacy_mask);
        fail_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_ch.ok !== want.ok) begin
          $display("%0t: ok expected %0b, got %0b", $time, want.ok, out_ch.ok);
          fail_count++;
        end
        if (out_ch.error_code !== want.error_code) begin
          $display("%0t: error_code expected %0d, got %0d", $time, want.error_code,
                   out_ch.error_code);
          fail_count++;
        end
        if (out_ch.privacy_mask !== want.privacy_mask) begin
          $display("%0t: privacy_mask expected %h, got %h", $time, want.privacy_mask,
                   out_ch.privacy_mask);
          fail_count++;
        end
        if (want.ok) clean_verdicts++;
        else error_verdicts++;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [7:0]  text [$];
    bit          bare_end;
    bit          hold_issued;
    int unsigned rand_base;
    int unsigned done;
    hold_issued = 1'b0;
    clear_parser();
    rst_ni         <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.has_char <= 1'b0;
    in_ch.ch       <= 8'h00;
    in_ch.last     <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_cases[i]) begin
      text = {};
      for (int j = 0; j < dir_cases[i].body.len(); j++) text.push_back(dir_cases[i].body[j]);
      if (dir_cases[i].tail_en) text.push_back(dir_cases[i].tail);
      typed_pending = dir_cases[i].typed;
      typed_verdict = dir_cases[i].verdict;
      send_body(text, dir_cases[i].bare_end, 0);
    end

    rand_base = chars_sent;
    while (chars_sent - rand_base < RANDOM_CHARS) begin
      done = chars_sent - rand_base;
      if (done >= 2 * RANDOM_CHARS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (!hold_issued) begin
          hold_req    = 1'b1;
          hold_issued = 1'b1;
        end
      end else if (done >= RANDOM_CHARS / 3) begin
        tx_idle_pct = 51;
        rx_idle_pct = 19;
      end
      make_body(text, bare_end);
      send_body(text, bare_end, 5);
    end
    in_ch.valid <= 1'b0;

    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Parsed %0d header bodies with %0d characters: %0d clean verdicts, %0d errors.",
             bodies_sent, chars_sent, clean_verdicts, error_verdicts);
    $display("Both idling mixes, a long result hold-off and back-to-back items were covered.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
